>>> rtl/core/tfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants of the timed hysteresis fan controller.
// ----------------------------------------------------------------------------
package tfc_pkg;

	localparam int TEMP_W       = 13;
	localparam int STAMP_W      = 32;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int TIME_BITS_DEF = 32;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_ALERT = 2'd1,
		MODE_VENT  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ON_THR  = 2'd0,
		REG_OFF_THR = 2'd1,
		REG_DELAY   = 2'd2,
		REG_HOLD    = 2'd3
	} reg_idx_t;

	localparam logic signed [TEMP_W-1:0] ON_THR_RST  = 13'sd480;
	localparam logic signed [TEMP_W-1:0] OFF_THR_RST = 13'sd400;
	localparam logic [STAMP_W-1:0]       DELAY_RST   = 32'd60000000;
	localparam logic [STAMP_W-1:0]       HOLD_RST    = 32'd120000000;

	typedef struct packed {
		logic signed [TEMP_W-1:0] on_thr;
		logic signed [TEMP_W-1:0] off_thr;
		logic [STAMP_W-1:0]       delay_us;
		logic [STAMP_W-1:0]       hold_us;
	} cfg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic [STAMP_W-1:0]       now_us;
	} beat_t;

endpackage
`default_nettype wire

>>> rtl/core/tfc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_in_stage
// Input register: holds one accepted beat until the control stage takes it.
// ----------------------------------------------------------------------------
module tfc_in_stage
	import tfc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire beat_t in_beat,
	input  wire logic  take,
	output logic       valid_s1,
	output beat_t      beat_s1
);

	logic load;

	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1 <= in_beat;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/tfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_ctrl
// Mode machine, timers and result register. One beat is evaluated per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
module tfc_ctrl
	import tfc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  valid_s1,
	input  wire beat_t beat_s1,
	output logic       take,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic       fan_on,
	output logic [1:0] mode_out
);

	// compare width covers both the timer and the 32-bit delay registers
	localparam int CW = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;

	mode_t                mode_q, mode_d;
	logic                 ot_active_q, ot_active_d;
	logic [TIME_BITS-1:0] ot_start_q, ot_start_d;
	logic [TIME_BITS-1:0] fan_start_q, fan_start_d;
	logic                 fan_q, fan_d;

	logic [CW-1:0]        now_w;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] ot_start_eff;
	logic [TIME_BITS-1:0] ot_elapsed, fan_elapsed;
	logic                 hot, cool, ot_done, hold_done;

	assign take = valid_s1 && (!out_valid || !out_stall);

	assign now_w = CW'(beat_s1.now_us);
	assign now_t = now_w[TIME_BITS-1:0];

	assign hot  = beat_s1.temperature > cfg.on_thr;
	assign cool = beat_s1.temperature < cfg.off_thr;

	// a fresh over-temperature starts its timer on this very beat
	assign ot_start_eff = ot_active_q ? ot_start_q : now_t;
	assign ot_elapsed   = now_t - ot_start_eff;
	assign fan_elapsed  = now_t - fan_start_q;
	assign ot_done      = CW'(ot_elapsed) >= CW'(cfg.delay_us);
	assign hold_done    = CW'(fan_elapsed) >= CW'(cfg.hold_us);

	// next mode
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_IDLE: begin
				if (hot) mode_d = MODE_ALERT;
			end
			MODE_ALERT: begin
				if (!hot) mode_d = MODE_IDLE;
				else if (ot_done) mode_d = MODE_VENT;
			end
			MODE_VENT: begin
				if (cool || hold_done) mode_d = MODE_IDLE;
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

	// timer and fan updates
	always_comb begin
		ot_active_d = ot_active_q;
		ot_start_d  = ot_start_q;
		fan_start_d = fan_start_q;
		fan_d       = fan_q;
		unique case (mode_q)
			MODE_IDLE: begin
				ot_active_d = hot;
				if (hot && !ot_active_q) ot_start_d = now_t;
			end
			MODE_ALERT: begin
				if (hot) begin
					ot_start_d  = ot_start_eff;
					ot_active_d = !ot_done;
					if (ot_done) begin
						fan_d       = 1'b1;
						fan_start_d = now_t;
					end
				end else begin
					ot_active_d = 1'b0;
				end
			end
			MODE_VENT: begin
				if (cool || hold_done) fan_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			ot_active_q <= 1'b0;
			ot_start_q  <= '0;
			fan_start_q <= '0;
			fan_q       <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (take) begin
				mode_q      <= mode_d;
				ot_active_q <= ot_active_d;
				ot_start_q  <= ot_start_d;
				fan_start_q <= fan_start_d;
				fan_q       <= fan_d;
				out_valid   <= 1'b1;
			end else if (!out_stall) begin
				out_valid   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fan_on   <= fan_d;
			mode_out <= mode_d;
		end
	end

	// fan runs exactly while venting
	a_fan_mode: assert property (@(posedge clk) disable iff (!arst_n)
		fan_q == (mode_q == MODE_VENT))
		else $error("fan state out of step with mode");

	// over-temperature timer only lives in alert
	a_ot_alert: assert property (@(posedge clk) disable iff (!arst_n)
		ot_active_q |-> (mode_q == MODE_ALERT))
		else $error("over-temperature timer active outside alert");

	// fan start time is the stamp of the beat that started it
	a_fan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode_q == MODE_ALERT && mode_d == MODE_VENT)
		|=> fan_start_q == $past(now_t))
		else $error("fan start time not taken from the starting beat");

	// result register reflects the committed state
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (fan_on == fan_q) && (mode_out == mode_q))
		else $error("result beat does not match state");

endmodule
`default_nettype wire

>>> rtl/core/timed_hysteresis_fan_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_hysteresis_fan_controller
// Three-mode thermostat fan control with over-temperature delay and fan hold.
// ----------------------------------------------------------------------------
// One control tick per cycle, sustained while the result is not stalled. A
// tick lands in the input register, then the mode machine evaluates it
// against the stored timers and writes the result register. The mode/timer
// update loop sets that rate. A stalled result holds the control stage; one
// more tick waits in the input register before in_stall rises. Temperatures
// are signed 1/16 degC; elapsed times are wrapping differences modulo
// 2^TIME_BITS. Write configuration only while no tick is in flight.
module timed_hysteresis_fan_controller
	import tfc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [TEMP_W-1:0] temperature,
	input  wire logic [STAMP_W-1:0]    now_us,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       fan_on,
	output logic [1:0]                 mode_out
);

	cfg_t  cfg_q;
	beat_t in_beat;
	beat_t beat_s1;
	logic  valid_s1;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_thr   <= ON_THR_RST;
			cfg_q.off_thr  <= OFF_THR_RST;
			cfg_q.delay_us <= DELAY_RST;
			cfg_q.hold_us  <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ON_THR:  cfg_q.on_thr   <= cfg_data[TEMP_W-1:0];
				REG_OFF_THR: cfg_q.off_thr  <= cfg_data[TEMP_W-1:0];
				REG_DELAY:   cfg_q.delay_us <= cfg_data[STAMP_W-1:0];
				REG_HOLD:    cfg_q.hold_us  <= cfg_data[STAMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_beat.temperature = temperature;
	assign in_beat.now_us      = now_us;

	tfc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.take     (take),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	tfc_ctrl #(
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.beat_s1   (beat_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.fan_on    (fan_on),
		.mode_out  (mode_out)
	);

endmodule
`default_nettype wire

>>> tb/tb_timed_hysteresis_fan_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_hysteresis_fan_controller
// Self-checking bench for the three-mode fan controller. A cycle-free model of
// the mode machine predicts fan drive and mode for every accepted tick; the
// result checker compares each result beat against the oldest prediction.
// Directed ticks cover threshold equality, exact delay and hold expiry, wrap
// of the timestamp and zero delays; random phases sweep register settings
// and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_timed_hysteresis_fan_controller;
	import tfc_pkg::*;

	typedef struct packed {
		logic  fan_on;
		mode_t mode_out;
	} fan_result_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index   = '0;
	logic [CFG_DATA_W-1:0]       cfg_data    = '0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic signed [TEMP_W-1:0]    temperature = '0;
	logic [STAMP_W-1:0]          now_us      = '0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic                        fan_on;
	logic [1:0]                  mode_out;

	timed_hysteresis_fan_controller dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.temperature (temperature),
		.now_us      (now_us),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fan_on      (fan_on),
		.mode_out    (mode_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("** timed_hysteresis_fan_controller: FAILED **");
		$finish;
	end

	// controller copy: registers and mode machine state
	logic signed [TEMP_W-1:0] cfg_on    = ON_THR_RST;
	logic signed [TEMP_W-1:0] cfg_off   = OFF_THR_RST;
	logic [STAMP_W-1:0]       cfg_delay = DELAY_RST;
	logic [STAMP_W-1:0]       cfg_hold  = HOLD_RST;
	mode_t                    ctl_mode    = MODE_IDLE;
	logic                     ot_active   = 1'b0;
	logic [STAMP_W-1:0]       ot_start    = '0;
	logic [STAMP_W-1:0]       vent_start  = '0;
	logic                     fan_running = 1'b0;

	fan_result_t pending_results[$];
	int          mismatch_count = 0;
	int          send_idle_pct  = 0;
	int          stall_pct      = 0;
	logic [STAMP_W-1:0] cur_stamp  = '0;
	logic [STAMP_W-1:0] time_scale = 32'd8;
	logic               heat       = 1'b0;

	function automatic fan_result_t step_controller(input logic signed [TEMP_W-1:0] t,
			input logic [STAMP_W-1:0] now);
		fan_result_t        r;
		logic [STAMP_W-1:0] since;
		case (ctl_mode)
		MODE_IDLE: begin
			if (t > cfg_on) begin
				if (!ot_active) begin
					ot_active = 1'b1;
					ot_start  = now;
				end
				ctl_mode = MODE_ALERT;
			end else begin
				ot_active = 1'b0;
			end
		end
		MODE_ALERT: begin
			if (t > cfg_on) begin
				if (!ot_active) begin
					ot_active = 1'b1;
					ot_start  = now;
				end
				since = now - ot_start;
				if (since >= cfg_delay) begin
					fan_running = 1'b1;
					vent_start  = now;
					ctl_mode    = MODE_VENT;
					ot_active   = 1'b0;
				end
			end else begin
				ot_active = 1'b0;
				ctl_mode  = MODE_IDLE;
			end
		end
		MODE_VENT: begin
			since = now - vent_start;
			if (t < cfg_off || since >= cfg_hold) begin
				fan_running = 1'b0;
				ctl_mode    = MODE_IDLE;
			end
		end
		default: ctl_mode = MODE_IDLE;
		endcase
		r.fan_on   = fan_running;
		r.mode_out = ctl_mode;
		return r;
	endfunction

	// threshold word: sign-extended or with junk above bit 12
	function automatic logic [CFG_DATA_W-1:0] thr_word(input logic signed [TEMP_W-1:0] v);
		if ($urandom_range(0, 1))
			return {19'($urandom), v};
		return {{19{v[TEMP_W-1]}}, v};
	endfunction

	function automatic logic signed [TEMP_W-1:0] pick_temp();
		int r;
		int d;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 7) == 0)
			heat = ~heat;
		if (r < 60) begin
			// sustained heat or cool spell
			if (heat)
				return cfg_on + TEMP_W'($urandom_range(1, 40));
			return cfg_off - TEMP_W'($urandom_range(1, 40));
		end
		d = int'($urandom_range(0, 6)) - 3;
		if (r < 75)
			return cfg_on + TEMP_W'(d);
		if (r < 88)
			return cfg_off + TEMP_W'(d);
		if (r < 95)
			return TEMP_W'(int'($urandom_range(0, 3200)) - 800);
		return TEMP_W'($urandom);
	endfunction

	function automatic logic [STAMP_W-1:0] next_stamp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 90)
			cur_stamp = cur_stamp + $urandom_range(0, time_scale);
		else if (r < 95)
			cur_stamp = $urandom;
		else
			cur_stamp = cur_stamp - $urandom_range(0, time_scale);
		return cur_stamp;
	endfunction

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin : result_check
		fan_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no tick pending: fan_on %0d mode_out %0d",
					fan_on, mode_out);
				mismatch_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (fan_on !== exp_r.fan_on) begin
					$error("fan_on: expected %0d, got %0d", exp_r.fan_on, fan_on);
					mismatch_count++;
				end
				if (mode_out !== exp_r.mode_out) begin
					$error("mode_out: expected %0d, got %0d", exp_r.mode_out, mode_out);
					mismatch_count++;
				end
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_tick(input logic signed [TEMP_W-1:0] t, input logic [STAMP_W-1:0] stamp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		temperature <= t;
		now_us      <= stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(step_controller(t, stamp));
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_config(input logic signed [TEMP_W-1:0] on_thr,
			input logic signed [TEMP_W-1:0] off_thr,
			input logic [STAMP_W-1:0] delay_us, input logic [STAMP_W-1:0] hold_us);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ON_THR;
		cfg_data  <= thr_word(on_thr);
		@(negedge clk);
		cfg_index <= REG_OFF_THR;
		cfg_data  <= thr_word(off_thr);
		@(negedge clk);
		cfg_index <= REG_DELAY;
		cfg_data  <= delay_us;
		@(negedge clk);
		cfg_index <= REG_HOLD;
		cfg_data  <= hold_us;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_on    = on_thr;
		cfg_off   = off_thr;
		cfg_delay = delay_us;
		cfg_hold  = hold_us;
		@(negedge clk);
	endtask

	// reset registers: threshold equality, exact delay, off-threshold edge
	task automatic test_default_timing();
		send_tick(13'sd480, 32'd0);
		send_tick(13'sd481, 32'd1000);
		send_tick(13'sd481, 32'd1000 + 32'd59999999);
		send_tick(13'sd481, 32'd1000 + 32'd60000000);
		send_tick(13'sd400, 32'd60001005);
		send_tick(13'sd399, 32'd60001010);
	endtask

	task automatic test_field_extremes();
		send_tick(13'h0FFF, 32'hFFFF_FFF0);
		send_tick(13'h1000, 32'h0000_0000);
		send_tick(13'h0FFF, 32'hFFFF_FFF0);
		// elapsed across the wrap equals the reset delay exactly
		send_tick(13'h0FFF, 32'h0393_86F0);
		send_tick(13'h0000, 32'hFFFF_FFFF);
		send_tick(13'h1FFF, 32'h0000_0000);
		send_tick(13'h0AAA, 32'hAAAA_AAAA);
		send_tick(13'h1555, 32'h5555_5555);
	endtask

	task automatic test_zero_delay_and_hold();
		wait_drain();
		write_config(ON_THR_RST, OFF_THR_RST, 32'd0, 32'd0);
		// entry tick never starts the fan, the next alert tick does
		send_tick(13'sd1000, 32'd500);
		send_tick(13'sd1000, 32'd500);
		send_tick(13'sd1000, 32'd500);
		wait_drain();
		write_config(ON_THR_RST, OFF_THR_RST, 32'd0, 32'd100);
		send_tick(13'sd1000, 32'd600);
		send_tick(13'sd1000, 32'd600);
		send_tick(13'sd1000, 32'd699);
		send_tick(13'sd1000, 32'd700);
		send_tick(13'sd1000, 32'd800);
		send_tick(13'sd480, 32'd801);
	endtask

	task automatic test_random_phases();
		logic signed [TEMP_W-1:0] on_thr;
		logic signed [TEMP_W-1:0] off_thr;
		logic [STAMP_W-1:0]       delay_us;
		logic [STAMP_W-1:0]       hold_us;
		for (int p = 0; p < 12; p++) begin
			wait_drain();
			case (p % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 88; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 88; end
			default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			time_scale = 32'd8;
			case (p % 6)
			0: begin
				on_thr = 13'sd2400; off_thr = -13'sd800;
				delay_us = '0; hold_us = '0; time_scale = 32'd4;
			end
			1: begin
				on_thr = -13'sd800; off_thr = 13'sd2400;
				delay_us = '1; hold_us = '1; time_scale = 32'h4000_0000;
			end
			2: begin
				on_thr = 13'h0FFF; off_thr = 13'h1000;
				delay_us = $urandom_range(0, 20); hold_us = $urandom_range(0, 20);
			end
			3: begin
				on_thr = TEMP_W'(int'($urandom_range(0, 3200)) - 800);
				off_thr = TEMP_W'(int'($urandom_range(0, 3200)) - 800);
				delay_us = $urandom >> 3; hold_us = $urandom >> 3;
				time_scale = 32'h0800_0000;
			end
			default: begin
				on_thr = TEMP_W'(int'($urandom_range(0, 3200)) - 800);
				off_thr = on_thr - TEMP_W'($urandom_range(0, 200));
				delay_us = $urandom_range(0, 40); hold_us = $urandom_range(0, 60);
			end
			endcase
			write_config(on_thr, off_thr, delay_us, hold_us);
			cur_stamp = $urandom;
			heat = 1'b0;
			repeat (110)
				send_tick(pick_temp(), next_stamp());
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_timing();
		test_field_extremes();
		test_zero_delay_and_hold();
		test_random_phases();
		send_idle_pct = 0;
		stall_pct     = 0;
		wait_drain();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("** timed_hysteresis_fan_controller: PASSED **");
		else
			$display("** timed_hysteresis_fan_controller: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/tfc_pkg.sv
rtl/core/tfc_in_stage.sv
rtl/core/tfc_ctrl.sv
rtl/core/timed_hysteresis_fan_controller.sv
tb/tb_timed_hysteresis_fan_controller.sv
